@@ rtl/sbus_pkg.sv @@
// Shared types, constants and decode tables for the serial frame receiver.
package sbus_pkg;

	localparam int DATA_BYTES = 23;
	localparam int CHAN_SLOTS = 16;

	localparam logic [7:0]  START_BYTE_RST = 8'd15;
	localparam logic [7:0]  END_MASK_RST   = 8'd0;
	localparam logic [15:0] GAP_LIMIT_RST  = 16'd3000;

	localparam logic signed [12:0] CH0_BIAS  = 13'sd1696;
	localparam logic signed [12:0] CH_CENTER = 13'sd1024;
	localparam logic signed [11:0] DIG_HIGH  = 12'sd800;
	localparam logic signed [11:0] DIG_LOW   = -12'sd800;

	localparam int FLAG_FAILSAFE = 2;

	typedef enum logic [1:0] {
		REG_START_BYTE = 2'd0,
		REG_END_MASK   = 2'd1,
		REG_GAP_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_DATA = 2'd1,
		PH_END  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_FLAG,
		DEC_FETCH,
		DEC_EMIT
	} dec_state_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [15:0] gap_us;
	} in_item_t;

	typedef struct packed {
		logic [4:0]         channel_index;
		logic signed [11:0] channel_value;
		logic               failsafe;
		logic [15:0]        error_total;
		logic               last;
	} out_item_t;

	// Raw channel feeding each output slot: slot 0 takes ch3, slots 1..3 take ch1, ch2, ch4.
	function automatic logic [3:0] raw_sel(input logic [3:0] slot);
		logic [3:0] k;
		case (slot)
			4'd0: k = 4'd2;
			4'd1: k = 4'd0;
			4'd2: k = 4'd1;
			default: k = slot;
		endcase
		return k;
	endfunction

	// First bit of an 11-bit packed channel.
	function automatic logic [7:0] chan_bit(input logic [3:0] k);
		return 8'({4'd0, k} * 8'd11);
	endfunction

endpackage

@@ rtl/sbus_frame_receiver_top.sv @@
// Top level: byte framing state machine, configuration registers, frame store and decoder.
//
//  channel | valid     | stall     | payload          | dir
//  in      | in_valid  | in_stall  | in_item  (24 b)  | to block
//  out     | out_valid | out_stall | out_item (35 b)  | from block
//  cfg     | cfg_we    | -         | cfg_index, cfg_data | to block
//
// A byte is accepted when in_valid is high and in_stall is low; in_stall stays low except while the decoder runs.
// A good end byte starts the decoder: it reads the flag byte and emits one failsafe result, or
// emits each channel after fetching it through the single frame-store read port (three byte
// reads per channel) and then the two digital channels; each result waits while out_stall is high.
// Reset clears phase, byte count, nonzero flag, fault count and registers; the store is not cleared.
module sbus_frame_receiver_top #(
	parameter int DATA_BYTES = sbus_pkg::DATA_BYTES,
	localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1,
	localparam int CW = $clog2(DATA_BYTES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sbus_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output sbus_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [7:0]  start_byte_q;
	logic [7:0]  end_mask_q;
	logic [15:0] gap_limit_q;

	sbus_pkg::phase_t phase_q, phase_d, phase_eff;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          nz_q, nz_d;
	logic          accept;
	logic          ram_we;
	logic          start;
	logic          busy;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= sbus_pkg::START_BYTE_RST;
			end_mask_q   <= sbus_pkg::END_MASK_RST;
			gap_limit_q  <= sbus_pkg::GAP_LIMIT_RST;
		end else if (cfg_we) begin
			case (sbus_pkg::cfg_reg_t'(cfg_index))
				sbus_pkg::REG_START_BYTE: start_byte_q <= cfg_data[7:0];
				sbus_pkg::REG_END_MASK:   end_mask_q   <= cfg_data[7:0];
				sbus_pkg::REG_GAP_LIMIT:  gap_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		// A long gap drops any partial frame before the byte is handled.
		phase_eff = (in_item.gap_us > gap_limit_q) ? sbus_pkg::PH_HUNT : phase_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		nz_d    = nz_q;
		ram_we  = 1'b0;
		start   = 1'b0;
		if (accept) begin
			case (phase_eff)
				sbus_pkg::PH_DATA: begin
					ram_we = 1'b1;
					cnt_d  = cnt_q + CW'(1);
					phase_d = sbus_pkg::PH_DATA;
					if (cnt_d >= CW'(DATA_BYTES)) begin
						cnt_d   = CW'(DATA_BYTES);
						phase_d = sbus_pkg::PH_END;
					end
					if (in_item.rx_byte != 8'd0) begin
						nz_d = 1'b1;
					end
				end
				sbus_pkg::PH_END: begin
					phase_d = sbus_pkg::PH_HUNT;
					start = ((in_item.rx_byte & end_mask_q) == 8'd0) && nz_q;
				end
				default: begin
					phase_d = sbus_pkg::PH_HUNT;
					if (in_item.rx_byte == start_byte_q) begin
						phase_d = sbus_pkg::PH_DATA;
						cnt_d   = '0;
						nz_d    = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbus_pkg::PH_HUNT;
			cnt_q   <= '0;
			nz_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			nz_q    <= nz_d;
		end
	end

	sbus_ram #(
		.WIDTH(8),
		.DEPTH(DATA_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(in_item.rx_byte),
		.raddr(raddr),
		.rdata(rdata)
	);

	sbus_decoder #(
		.DATA_BYTES(DATA_BYTES)
	) u_decoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.raddr    (raddr),
		.rdata    (rdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	a_store_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> cnt_q < CW'(DATA_BYTES) && phase_q == sbus_pkg::PH_DATA)
		else $error("store write outside data phase or range");

endmodule

@@ rtl/sbus_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbus_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sbus_pkg::DATA_BYTES,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sbus_decoder.sv @@
// Frame decoder: reads the stored frame back, checks the flag byte and emits results.
module sbus_decoder #(
	parameter int DATA_BYTES = sbus_pkg::DATA_BYTES,
	localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic [AW-1:0]       raddr,
	input  logic [7:0]          rdata,
	output logic                out_valid,
	input  logic                out_stall,
	output sbus_pkg::out_item_t out_item
);

	localparam logic [AW-1:0] FLAG_ADDR = AW'(DATA_BYTES - 1);

	sbus_pkg::dec_state_t state_q, state_d;
	logic [4:0]  slot_q, slot_d;
	logic [1:0]  j_q, j_d;
	logic [15:0] fault_q, fault_d;
	logic [15:0] word_q, word_d;
	logic [1:0]  flags_q, flags_d;
	sbus_pkg::out_item_t out_q, out_d;

	logic [3:0]  raw_k;
	logic [7:0]  bit_pos;
	logic [23:0] word24;
	logic [10:0] raw;
	logic signed [12:0] raw_ext;
	logic signed [12:0] val13;
	logic [4:0]  slot_n;
	logic [15:0] fault_inc;

	assign raw_k   = sbus_pkg::raw_sel(slot_q[3:0]);
	assign bit_pos = sbus_pkg::chan_bit(raw_k);
	assign word24  = {rdata, word_q};
	assign raw     = 11'(word24 >> bit_pos[2:0]);
	assign raw_ext = $signed({2'b00, raw});
	assign slot_n  = slot_q + 5'd1;
	assign fault_inc = (fault_q == 16'hFFFF) ? fault_q : fault_q + 16'd1;

	always_comb begin
		case (slot_q)
			5'd0: val13 = sbus_pkg::CH0_BIAS - raw_ext;
			5'd1, 5'd2, 5'd3: val13 = raw_ext - sbus_pkg::CH_CENTER;
			default: val13 = sbus_pkg::CH_CENTER - raw_ext;
		endcase
	end

	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		j_d     = j_q;
		fault_d = fault_q;
		word_d  = word_q;
		flags_d = flags_q;
		out_d   = out_q;
		raddr   = FLAG_ADDR;
		case (state_q)
			sbus_pkg::DEC_IDLE: begin
				if (start) begin
					state_d = sbus_pkg::DEC_FLAG;
				end
			end
			sbus_pkg::DEC_FLAG: begin
				flags_d = rdata[1:0];
				if (rdata[sbus_pkg::FLAG_FAILSAFE]) begin
					fault_d = fault_inc;
					out_d = '{channel_index: 5'd0, channel_value: 12'sd0, failsafe: 1'b1,
						error_total: fault_inc, last: 1'b1};
					state_d = sbus_pkg::DEC_EMIT;
				end else begin
					slot_d  = 5'd0;
					j_d     = 2'd0;
					state_d = sbus_pkg::DEC_FETCH;
				end
			end
			sbus_pkg::DEC_FETCH: begin
				// Issue no read on the last fetch cycle; channel bytes never run past the flag byte.
				if (j_q != 2'd3) begin
					raddr = AW'(bit_pos[7:3]) + AW'(j_q);
				end
				j_d = j_q + 2'd1;
				case (j_q)
					2'd1: word_d[7:0]  = rdata;
					2'd2: word_d[15:8] = rdata;
					2'd3: begin
						out_d = '{channel_index: slot_q, channel_value: val13[11:0],
							failsafe: 1'b0, error_total: fault_q, last: 1'b0};
						state_d = sbus_pkg::DEC_EMIT;
					end
					default: ;
				endcase
			end
			sbus_pkg::DEC_EMIT: begin
				if (!out_stall) begin
					if (out_q.last) begin
						state_d = sbus_pkg::DEC_IDLE;
					end else begin
						slot_d = slot_n;
						if (slot_n >= 5'(sbus_pkg::CHAN_SLOTS)) begin
							// Digital channels come straight from the flag byte.
							out_d = '{channel_index: slot_n,
								channel_value: flags_q[slot_n[0]] ? sbus_pkg::DIG_HIGH
									: sbus_pkg::DIG_LOW,
								failsafe: 1'b0, error_total: fault_q,
								last: slot_n[0]};
						end else begin
							j_d     = 2'd0;
							state_d = sbus_pkg::DEC_FETCH;
						end
					end
				end
			end
			default: state_d = sbus_pkg::DEC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbus_pkg::DEC_IDLE;
			slot_q  <= 5'd0;
			j_q     <= 2'd0;
			fault_q <= 16'd0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			j_q     <= j_d;
			fault_q <= fault_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q  <= word_d;
		flags_q <= flags_d;
		out_q   <= out_d;
	end

	assign busy      = (state_q != sbus_pkg::DEC_IDLE);
	assign out_valid = (state_q == sbus_pkg::DEC_EMIT);
	assign out_item  = out_q;

	a_failsafe_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.failsafe |-> out_item.last && out_item.channel_index == 5'd0)
		else $error("failsafe item not a single final item");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == sbus_pkg::DEC_IDLE)
		else $error("frame start while decoder busy");

	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fault_q >= $past(fault_q))
		else $error("fault count decreased");

	a_fetch_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbus_pkg::DEC_FETCH |-> slot_q < 5'(sbus_pkg::CHAN_SLOTS))
		else $error("fetch for a digital channel slot");

endmodule

@@ tb/tb_sbus_frame_receiver_top.sv @@
// Testbench for the serial frame receiver: byte stimulus, frame decode prediction and result checks.
`timescale 1ns / 1ps

module tb_sbus_frame_receiver_top;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	sbus_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_stall;
	sbus_pkg::out_item_t out_item;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [15:0]         cfg_data;

	sbus_frame_receiver_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow registers and framing state of the receiver
	logic [7:0]       shadow_start;
	logic [7:0]       shadow_mask;
	logic [15:0]      shadow_gap;
	sbus_pkg::phase_t frame_phase;
	int               data_count;
	bit               data_nonzero;
	logic [7:0]       shadow_store [sbus_pkg::DATA_BYTES];
	logic [15:0]      fault_total;

	sbus_pkg::out_item_t pending_results[$];
	logic [7:0]          frame_buf [sbus_pkg::DATA_BYTES];

	int send_idle;
	int recv_idle;
	int hold_cycles;
	int items_sent;
	int mismatches;

	function automatic int raw_channel(input int k);
		int bitpos;
		int idx;
		int w;
		bitpos = 11 * k;
		idx = bitpos / 8;
		w = 0;
		for (int i = 0; i < 3; i++) begin
			if (idx + i < sbus_pkg::DATA_BYTES)
				w = w | (int'(shadow_store[idx + i]) << (8 * i));
		end
		return (w >> (bitpos % 8)) & 'h7FF;
	endfunction

	function automatic void push_result(input int idx, input int val, input bit fs,
			input bit lst);
		sbus_pkg::out_item_t r;
		r.channel_index = idx[4:0];
		r.channel_value = val[11:0];
		r.failsafe      = fs;
		r.error_total   = fault_total;
		r.last          = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void decode_frame();
		logic [7:0] flags;
		int raw;
		flags = shadow_store[sbus_pkg::DATA_BYTES - 1];
		if (flags[sbus_pkg::FLAG_FAILSAFE]) begin
			if (fault_total != 16'hFFFF)
				fault_total++;
			push_result(0, 0, 1'b1, 1'b1);
			return;
		end
		// Output slots 0..3 draw on ch3, ch1, ch2, ch4; slots 4..15 are inverted about center
		push_result(0, 1696 - raw_channel(2), 1'b0, 1'b0);
		push_result(1, raw_channel(0) - 1024, 1'b0, 1'b0);
		push_result(2, raw_channel(1) - 1024, 1'b0, 1'b0);
		push_result(3, raw_channel(3) - 1024, 1'b0, 1'b0);
		for (int k = 4; k < 16; k++) begin
			raw = raw_channel(k);
			push_result(k, 1024 - raw, 1'b0, 1'b0);
		end
		push_result(16, flags[0] ? 800 : -800, 1'b0, 1'b0);
		push_result(17, flags[1] ? 800 : -800, 1'b0, 1'b1);
	endfunction

	function automatic void decode_byte(input sbus_pkg::in_item_t it);
		if (it.gap_us > shadow_gap)
			frame_phase = sbus_pkg::PH_HUNT;
		case (frame_phase)
			sbus_pkg::PH_DATA: begin
				if (data_count < sbus_pkg::DATA_BYTES)
					shadow_store[data_count] = it.rx_byte;
				data_count++;
				if (data_count >= sbus_pkg::DATA_BYTES) begin
					data_count = sbus_pkg::DATA_BYTES;
					frame_phase = sbus_pkg::PH_END;
				end
				if (it.rx_byte != 8'd0)
					data_nonzero = 1'b1;
			end
			sbus_pkg::PH_END: begin
				frame_phase = sbus_pkg::PH_HUNT;
				if ((it.rx_byte & shadow_mask) == 8'd0 && data_nonzero)
					decode_frame();
			end
			default: begin
				frame_phase = sbus_pkg::PH_HUNT;
				if (it.rx_byte == shadow_start) begin
					frame_phase = sbus_pkg::PH_DATA;
					data_count = 0;
					data_nonzero = 1'b0;
				end
			end
		endcase
	endfunction

	// Result checker
	always @(posedge clk) begin
		sbus_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: idx=%0d val=%0d fs=%0b err=%0d last=%0b",
						out_item.channel_index, out_item.channel_value, out_item.failsafe,
						out_item.error_total, out_item.last);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.channel_index !== want.channel_index ||
						out_item.channel_value !== want.channel_value ||
						out_item.failsafe !== want.failsafe ||
						out_item.error_total !== want.error_total ||
						out_item.last !== want.last) begin
					if (mismatches < 10)
						$display("result mismatch: want idx=%0d val=%0d fs=%0b err=%0d last=%0b, %s",
							want.channel_index, want.channel_value, want.failsafe,
							want.error_total, want.last,
							$sformatf("got idx=%0d val=%0d fs=%0b err=%0d last=%0b",
								out_item.channel_index, out_item.channel_value,
								out_item.failsafe, out_item.error_total, out_item.last));
					mismatches++;
				end
			end
		end
	end

	// Receiver stall: long hold-off when requested, random otherwise
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic [15:0] g);
		sbus_pkg::in_item_t it;
		it.rx_byte = b;
		it.gap_us = g;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		decode_byte(it);
		items_sent++;
	endtask

	// Drop valid, drain all pending results, then let the decoder go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input sbus_pkg::cfg_reg_t r, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			sbus_pkg::REG_START_BYTE: shadow_start = v[7:0];
			sbus_pkg::REG_END_MASK:   shadow_mask = v[7:0];
			sbus_pkg::REG_GAP_LIMIT:  shadow_gap = v;
			default: ;
		endcase
		// hold write enable low before the next write
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_gap();
		if ($urandom_range(9) == 0)
			return shadow_gap;
		return 16'($urandom_range(0, shadow_gap));
	endfunction

	function automatic void fill_frame(input bit zero);
		for (int i = 0; i < sbus_pkg::DATA_BYTES; i++)
			frame_buf[i] = zero ? 8'd0 : 8'($urandom_range(255));
		if (!zero)
			frame_buf[sbus_pkg::DATA_BYTES - 1][sbus_pkg::FLAG_FAILSAFE] =
				($urandom_range(4) == 0);
	endfunction

	// Send start byte, n_data bytes of frame_buf and, for a full frame, the end byte.
	// A negative gap argument picks gaps at random.
	task automatic send_frame(input logic [7:0] end_b, input int n_data, input int start_gap,
			input int byte_gap);
		logic [15:0] g;
		if (start_gap >= 0) begin
			g = 16'(start_gap);
		end else if (shadow_gap != 16'hFFFF && $urandom_range(1)) begin
			g = 16'($urandom_range(shadow_gap + 1, 65535));
		end else begin
			// finish any open frame so the start byte is seen while hunting
			while (frame_phase != sbus_pkg::PH_HUNT)
				send_item(8'd0, pick_gap());
			g = pick_gap();
		end
		send_item(shadow_start, g);
		for (int i = 0; i < n_data; i++)
			send_item(frame_buf[i], (byte_gap >= 0) ? 16'(byte_gap) : pick_gap());
		if (n_data == sbus_pkg::DATA_BYTES)
			send_item(end_b, (byte_gap >= 0) ? 16'(byte_gap) : pick_gap());
	endtask

	task automatic test_directed();
		send_idle = 7;
		recv_idle = 62;
		// full-scale channels, both digital bits set, every gap at the limit
		fill_frame(1'b0);
		for (int i = 0; i < sbus_pkg::DATA_BYTES; i++)
			frame_buf[i] = 8'hFF;
		frame_buf[sbus_pkg::DATA_BYTES - 1] = 8'h03;
		send_frame(8'h00, sbus_pkg::DATA_BYTES, 3000, 3000);
		// zero channels, one digital bit
		fill_frame(1'b1);
		frame_buf[sbus_pkg::DATA_BYTES - 1] = 8'h01;
		send_frame(8'hFF, sbus_pkg::DATA_BYTES, 3001, 0);
		// failsafe flag
		fill_frame(1'b0);
		frame_buf[sbus_pkg::DATA_BYTES - 1] = 8'h04;
		send_frame(8'h00, sbus_pkg::DATA_BYTES, 3001, -1);
		// all data zero: no result
		fill_frame(1'b1);
		send_frame(8'h00, sbus_pkg::DATA_BYTES, 3001, -1);
		// gap above the limit in mid-frame restarts on the next start byte
		fill_frame(1'b0);
		send_frame(8'h00, 6, 3001, 100);
		send_frame(8'h00, sbus_pkg::DATA_BYTES, 3001, 2999);
	endtask

	task automatic test_register_extremes();
		settle();
		write_reg(sbus_pkg::REG_START_BYTE, 16'h0000);
		write_reg(sbus_pkg::REG_END_MASK, 16'h00FF);
		write_reg(sbus_pkg::REG_GAP_LIMIT, 16'h0000);
		fill_frame(1'b0);
		send_frame(8'h00, sbus_pkg::DATA_BYTES, -1, -1);
		// any end byte bit under the mask rejects the frame
		fill_frame(1'b0);
		send_frame(8'h80, sbus_pkg::DATA_BYTES, -1, -1);
		settle();
		write_reg(sbus_pkg::REG_START_BYTE, 16'h00FF);
		write_reg(sbus_pkg::REG_END_MASK, 16'h0000);
		write_reg(sbus_pkg::REG_GAP_LIMIT, 16'hFFFF);
		fill_frame(1'b0);
		send_frame(8'h7F, sbus_pkg::DATA_BYTES, 65535, -1);
		fill_frame(1'b0);
		send_frame(8'hFF, sbus_pkg::DATA_BYTES, -1, -1);
	endtask

	task automatic test_random(input int s_idle, input int r_idle, input int n_items);
		int stop;
		int r;
		logic [7:0] e;
		settle();
		send_idle = s_idle;
		recv_idle = r_idle;
		write_reg(sbus_pkg::REG_START_BYTE, 16'($urandom_range(255)));
		write_reg(sbus_pkg::REG_END_MASK,
			16'($urandom_range(1) ? 0 : (1 << $urandom_range(7))));
		write_reg(sbus_pkg::REG_GAP_LIMIT,
			16'($urandom_range(1) ? 3000 : $urandom_range(65535)));
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			fill_frame(r >= 80 && r < 85);
			e = 8'($urandom_range(255));
			if (r < 70 || (r >= 80 && r < 85)) begin
				send_frame(e & ~shadow_mask, sbus_pkg::DATA_BYTES, -1, -1);
			end else if (r < 80) begin
				send_frame(e | shadow_mask, sbus_pkg::DATA_BYTES, -1, -1);
			end else if (r < 92) begin
				send_frame(8'h00, int'($urandom_range(sbus_pkg::DATA_BYTES - 1)), -1, -1);
			end else begin
				repeat ($urandom_range(1, 5))
					send_item(8'($urandom_range(255)), 16'($urandom_range(65535)));
			end
		end
	endtask

	// Hold the receiver off so the decoder backs up and stalls incoming bytes
	task automatic test_backpressure();
		settle();
		send_idle = 0;
		recv_idle = 0;
		write_reg(sbus_pkg::REG_START_BYTE, 16'h000F);
		write_reg(sbus_pkg::REG_END_MASK, 16'h0000);
		write_reg(sbus_pkg::REG_GAP_LIMIT, 16'd3000);
		hold_cycles = 600;
		repeat (2) begin
			fill_frame(1'b0);
			frame_buf[sbus_pkg::DATA_BYTES - 1][sbus_pkg::FLAG_FAILSAFE] = 1'b0;
			send_frame(8'h00, sbus_pkg::DATA_BYTES, 3001, -1);
		end
	endtask

	initial begin
		int waited;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= sbus_pkg::REG_START_BYTE;
		cfg_data <= '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		items_sent = 0;
		mismatches = 0;
		shadow_start = sbus_pkg::START_BYTE_RST;
		shadow_mask = sbus_pkg::END_MASK_RST;
		shadow_gap = sbus_pkg::GAP_LIMIT_RST;
		frame_phase = sbus_pkg::PH_HUNT;
		data_count = 0;
		data_nonzero = 1'b0;
		fault_total = '0;
		for (int i = 0; i < sbus_pkg::DATA_BYTES; i++)
			shadow_store[i] = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_register_extremes();
		test_random(7, 62, 10);
		test_random(62, 7, 10);
		test_random(0, 0, 10);
		test_backpressure();

		in_valid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("tb_sbus_frame_receiver_top: PASS");
		else
			$display("tb_sbus_frame_receiver_top: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_sbus_frame_receiver_top: FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sbus_pkg.sv
rtl/sbus_ram.sv
rtl/sbus_decoder.sv
rtl/sbus_frame_receiver_top.sv
tb/tb_sbus_frame_receiver_top.sv
